// ===== hdl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg - shared types and constants for the positional list unit
// Holds the payload widths, the request command codes, the per-cycle cell
// operation code and the control bundle broadcast from the list controller to
// every storage cell.
// ----------------------------------------------------------------------------
package pidl_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned POS_W        = 5;

	// Request commands as carried on the command port
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} list_cmd_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] item;
	} cell_ctl_t;

endpackage

// ===== hdl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell - one storage cell of the list chain
// Holds one list entry. Takes its left neighbor's entry on an insert ahead of
// it, its right neighbor's entry on a delete at or ahead of it, and runs a tap
// register that carries a deleted entry toward the head of the chain.
// ----------------------------------------------------------------------------
module pidl_cell import pidl_pkg::*; #(
	parameter int unsigned INDEX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  logic [DATA_W-1:0] tap_in,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tap
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] tap_q;
	logic [31:0]       pos_ext;
	logic              at_pos;
	logic              past_pos;

	assign pos_ext  = 32'(ctl.pos);
	assign at_pos   = (32'(INDEX) == pos_ext);
	assign past_pos = (32'(INDEX) > pos_ext);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (past_pos) begin
					data_q <= left_data;
				end else if (at_pos) begin
					data_q <= ctl.item;
				end
			end
			OP_DEL: begin
				if (past_pos || at_pos) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	// capture the entry being deleted, otherwise advance the tap toward the head
	always_ff @(posedge clk) begin
		if (ctl.op == OP_DEL && at_pos) begin
			tap_q <= data_q;
		end else begin
			tap_q <= tap_in;
		end
	end

	assign data = data_q;
	assign tap  = tap_q;

endmodule

// ===== hdl/positional_insert_delete_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit - ordered list with positional insert and
// delete
// Keeps up to CAPACITY signed 32-bit entries in a chain of cells and a count.
// ----------------------------------------------------------------------------
// Each request inserts an item at a position from 0 to count or deletes the
// item at a position from 0 to count-1; every request gives exactly one result
// with ok, the removed item (zero unless a delete succeeded), the new count and
// an empty flag. A rejected request (bad position, insert into a full list,
// delete from an empty list) leaves the list untouched. The list lives in a
// chain of cells that all shift in the cycle the request is accepted, so the
// list update itself is done in that cycle. The deleted entry then travels
// toward the head of the chain one cell per cycle along a tap line: a request
// is taken when the unit is idle, then ST_RUN waits while wait_q counts down
// from the delete position (from zero for an insert or a rejected request),
// the removed item is registered from the head tap, and ST_DONE shows the
// result, which is held until taken; the next request is accepted in the
// cycle after that. Entry storage has no reset; only the count is cleared.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit import pidl_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic                     command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] item,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     ok,
	output logic signed [DATA_W-1:0] removed_item,
	output logic [POS_W-1:0]         count,
	output logic                     empty_res
);

	localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	logic [POS_W-1:0]  wait_q;
	logic              del_ok_q;
	logic              ok_q;
	logic [POS_W-1:0]  count_q;
	logic              empty_q;
	logic [DATA_W-1:0] removed_q;

	logic              accept;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  len_c;
	logic              ins_ok;
	logic              del_ok;
	logic [LEN_W-1:0]  len_next;
	logic [31:0]       len_ext;
	cell_ctl_t         ctl;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// validity of the request against the current length
	assign pos_c  = CMP_W'(position);
	assign len_c  = CMP_W'(len_q);
	assign ins_ok = (pos_c <= len_c) && (len_q < LEN_W'(CAPACITY));
	assign del_ok = (pos_c < len_c);

	always_comb begin
		len_next = len_q;
		if (command == CMD_INSERT && ins_ok) begin
			len_next = len_q + LEN_W'(1);
		end else if (command == CMD_DELETE && del_ok) begin
			len_next = len_q - LEN_W'(1);
		end
	end

	assign len_ext = 32'(len_next);

	// broadcast one operation to the whole chain; hold unless a valid request
	always_comb begin
		ctl.op   = OP_HOLD;
		ctl.pos  = position;
		ctl.item = $unsigned(item);
		if (accept) begin
			if (command == CMD_DELETE && del_ok) begin
				ctl.op = OP_DEL;
			end else if (command == CMD_INSERT && ins_ok) begin
				ctl.op = OP_INS;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		logic [DATA_W-1:0] tap_d;

		if (i == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = '0;
			assign tap_d   = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
			assign tap_d   = cell_tap[i+1];
		end

		pidl_cell #(
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_data (left_d),
			.right_data(right_d),
			.tap_in    (tap_d),
			.data      (cell_data[i]),
			.tap       (cell_tap[i])
		);
	end

	// sequence: take request, wait for the tap to reach the head, show result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						len_q   <= len_next;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (wait_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			del_ok_q <= (command == CMD_DELETE) && del_ok;
			ok_q     <= (command == CMD_DELETE) ? del_ok : ins_ok;
			count_q  <= len_ext[POS_W-1:0];
			empty_q  <= (len_next == '0);
			wait_q   <= ((command == CMD_DELETE) && del_ok) ? position : '0;
		end else if (state_q == ST_RUN) begin
			if (wait_q == '0) begin
				removed_q <= del_ok_q ? cell_tap[0] : '0;
			end else begin
				wait_q <= wait_q - POS_W'(1);
			end
		end
	end

	assign res_valid    = (state_q == ST_DONE);
	assign ok           = ok_q;
	assign removed_item = $signed(removed_q);
	assign count        = count_q;
	assign empty_res    = empty_q;

	// length never exceeds the cell count
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	// one request at a time: no second accept right after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request taken while another is in flight");

	// the empty flag agrees with the stored length while a result is shown
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (empty_res == (len_q == '0)))
		else $error("empty flag disagrees with length");

	// a rejected request never reports a removed item
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !ok) |-> (removed_q == '0))
		else $error("rejected request reports a removed item");

	// length holds unless a request is taken
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(len_q))
		else $error("length changed without a request");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench for positional_insert_delete_list_unit
// Drives insert and delete requests into the list unit and keeps a shadow
// list that works out the result of every accepted request. Each result from
// the unit is compared field by field with the oldest pending prediction. A
// short table of directed requests comes first, then random traffic under
// several idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import pidl_pkg::*;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] removed;
		logic [POS_W-1:0]         count;
		logic                     is_empty;
	} list_result_t;

	// One directed row; reps > 1 repeats the request with the item bumped by
	// one each time. Rows with typed set carry a hand-written result.
	typedef struct packed {
		list_cmd_t                cmd;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         reps;
		logic                     typed;
		list_result_t             golden;
	} stim_row_t;

	localparam int NUM_ROWS      = 15;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS   = 100;
	localparam int IDLE_LIMIT    = 5000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int MAX_PRINTS    = 50;

	localparam list_result_t NO_RESULT = '0;

	localparam stim_row_t directed_rows [NUM_ROWS] = '{
		// delete from an empty list, insert past the end of an empty list
		'{CMD_DELETE, 5'd0,  32'sd0,             5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  1'b1}},
		'{CMD_INSERT, 5'd1,  32'sd5,             5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  1'b1}},
		// extremes of the item, at the front and then at the end
		'{CMD_INSERT, 5'd0,  32'sh7FFFFFFF,      5'd1,  1'b1, '{1'b1, 32'sd0, 5'd1,  1'b0}},
		'{CMD_INSERT, 5'd1,  32'sh80000000,      5'd1,  1'b1, '{1'b1, 32'sd0, 5'd2,  1'b0}},
		'{CMD_INSERT, 5'd0,  -32'sd1,            5'd1,  1'b0, NO_RESULT},
		// bad positions on insert and delete
		'{CMD_INSERT, 5'd4,  32'sh00001234,      5'd1,  1'b1, '{1'b0, 32'sd0, 5'd3,  1'b0}},
		'{CMD_DELETE, 5'd3,  32'sh0BADF00D,      5'd1,  1'b1, '{1'b0, 32'sd0, 5'd3,  1'b0}},
		// delete from the middle, insert at the end, then drain from the front
		'{CMD_DELETE, 5'd1,  32'sd0,             5'd1,  1'b0, NO_RESULT},
		'{CMD_INSERT, 5'd2,  32'sd0,             5'd1,  1'b0, NO_RESULT},
		'{CMD_DELETE, 5'd0,  32'sd0,             5'd3,  1'b0, NO_RESULT},
		// fill to capacity from the front
		'{CMD_INSERT, 5'd0,  32'shA5A50000,      5'd16, 1'b0, NO_RESULT},
		// insert into a full list, delete past the last position of a full list
		'{CMD_INSERT, 5'd16, 32'sh13572468,      5'd1,  1'b1, '{1'b0, 32'sd0, 5'd16, 1'b0}},
		'{CMD_DELETE, 5'd16, 32'sd0,             5'd1,  1'b1, '{1'b0, 32'sd0, 5'd16, 1'b0}},
		// delete the last entry (longest tap walk), then put one back there
		'{CMD_DELETE, 5'd15, 32'sd0,             5'd1,  1'b0, NO_RESULT},
		'{CMD_INSERT, 5'd15, 32'sh5A5A5A5A,      5'd1,  1'b0, NO_RESULT}
	};

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     req_valid    = 1'b0;
	logic                     req_ready;
	logic                     command      = CMD_INSERT;
	logic [POS_W-1:0]         position     = '0;
	logic signed [DATA_W-1:0] item         = '0;
	logic                     res_valid;
	logic                     res_ready    = 1'b0;
	logic                     ok;
	logic signed [DATA_W-1:0] removed_item;
	logic [POS_W-1:0]         count;
	logic                     empty_res;

	// Shadow copy of the list, front at index 0, and the results still owed
	logic signed [DATA_W-1:0] list_contents [$];
	list_result_t             pending_results [$];

	int  mismatches     = 0;
	int  idle_cycles    = 0;
	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  filling        = 1'b1;

	positional_insert_delete_list_unit #(
		.CAPACITY(CAPACITY_DEF)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.position     (position),
		.item         (item),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.ok           (ok),
		.removed_item (removed_item),
		.count        (count),
		.empty_res    (empty_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow list and work out the unit's answer.
	// Rejected requests leave the list alone and report removed as zero.
	task automatic apply_list_op(input list_cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val, output list_result_t res);
		res = '0;
		if (cmd == CMD_INSERT) begin
			if (pos <= list_contents.size() && list_contents.size() < CAPACITY_DEF) begin
				list_contents.insert(pos, val);
				res.ok = 1'b1;
			end
		end else begin
			if (pos < list_contents.size()) begin
				res.removed = list_contents[pos];
				list_contents.delete(pos);
				res.ok = 1'b1;
			end
		end
		res.count    = POS_W'(list_contents.size());
		res.is_empty = (list_contents.size() == 0);
	endtask

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (mismatches < MAX_PRINTS)
			$display("tb: mismatch on %s at %0t: got %0h, want %0h", field, $realtime, got,
				want);
		mismatches++;
	endtask

	// Present one request, honoring the sender idle rate, and hold it until
	// accepted. Valid stays high on return so back-to-back requests need no
	// second assignment in the same step.
	task automatic send_request(input list_cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val, input logic use_golden,
			input list_result_t golden);
		list_result_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		position  <= pos;
		item      <= val;
		do
			@(posedge clk);
		while (!req_ready);
		apply_list_op(cmd, pos, val, predicted);
		pending_results.push_back(use_golden ? golden : predicted);
	endtask

	// Drop valid and hold off until every owed result has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: pick_value = 32'sh7FFFFFFF;
			1: pick_value = 32'sh80000000;
			2: pick_value = 32'sd0;
			3: pick_value = -32'sd1;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Random request: mostly legal positions so the list sweeps between empty
	// and full, with some arbitrary positions mixed in to hit the rejects.
	task automatic send_random_request();
		list_cmd_t        cmd;
		logic [POS_W-1:0] pos;
		int               len;
		len = list_contents.size();
		if (len == CAPACITY_DEF)
			filling = 1'b0;
		else if (len == 0)
			filling = 1'b1;
		else if ($urandom_range(39) == 0)
			filling = !filling;
		cmd = ($urandom_range(99) < (filling ? 75 : 25)) ? CMD_INSERT : CMD_DELETE;
		if ($urandom_range(99) < 15)
			pos = POS_W'($urandom_range(CAPACITY_DEF));
		else if (cmd == CMD_INSERT)
			pos = POS_W'($urandom_range(len));
		else
			pos = (len == 0) ? 5'd0 : POS_W'($urandom_range(len - 1));
		send_request(cmd, pos, pick_value(), 1'b0, NO_RESULT);
	endtask

	// Receiver side: stall at the current rate
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {31'd0, ok}, '0);
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", {31'd0, ok}, {31'd0, want.ok});
				if (removed_item !== want.removed)
					report_mismatch("removed_item", removed_item, want.removed);
				if (count !== want.count)
					report_mismatch("count", {27'd0, count}, {27'd0, want.count});
				if (empty_res !== want.is_empty)
					report_mismatch("empty_res", {31'd0, empty_res}, {31'd0, want.is_empty});
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int phase_stall [RANDOM_PHASES];
		int phase_idle [RANDOM_PHASES];
		phase_idle  = '{0, 73, 0, 12};
		phase_stall = '{0, 0, 73, 12};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling on either side
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				send_request(directed_rows[r].cmd, directed_rows[r].pos,
					directed_rows[r].val + k, directed_rows[r].typed,
					directed_rows[r].golden);
			end
		end
		wait_for_results();

		// Random traffic; each phase changes the idling pattern once the
		// unit has drained, so the sender pause lands between phases
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct  = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			repeat (PHASE_ITEMS) send_random_request();
			wait_for_results();
		end

		// Let any stray result show up before the verdict
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
